>>> rtl/lcw_pkg.sv
// Shared types, constants and the event-time table of the column-wave engine.
`timescale 1ns / 1ps
`default_nettype none
package lcw_pkg;

   localparam int LANES     = 8;
   localparam int LANE_W    = 3;
   localparam int TABLE_LEN = 14;
   localparam int POS_W     = 4;
   localparam int TIME_W    = 11;
   localparam int HGT_W     = 3;
   localparam int COUNT_W   = 17;
   localparam int REP_W     = 16;
   localparam int COORD_W   = 3;

   localparam logic [TIME_W-1:0]  TIME_WRAP  = 11'd2000;
   localparam logic [TIME_W-1:0]  RISE_LIMIT = 11'd1000;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 17'h1FFFF;

   // Register indexes on the csr channel
   localparam logic [1:0] CSR_MODE   = 2'd0;
   localparam logic [1:0] CSR_PLANE  = 2'd1;
   localparam logic [1:0] CSR_REPEAT = 2'd2;

   // Modes 4..7 all mean "none"; only bit 2 is needed to spot them
   typedef enum logic [2:0] {
      MODE_DIAG45  = 3'd0,
      MODE_DIAG135 = 3'd1,
      MODE_XPLANE  = 3'd2,
      MODE_YPLANE  = 3'd3,
      MODE_NONE    = 3'd4
   } mode_type;

   // Result slot carried down the cell chain
   typedef struct packed {
      logic [HGT_W-1:0] height;
      logic             moved;
   } slot_type;

   // Lane status seen by the round counter
   typedef struct packed {
      logic             hit;
      logic [HGT_W-1:0] height_next;
   } lane_stat_type;

   function automatic logic [TIME_W-1:0] event_time(input logic [POS_W-1:0] p);
      logic [TIME_W-1:0] t;
      case (p)
         4'd0:    t = 11'd246;
         4'd1:    t = 11'd359;
         4'd2:    t = 11'd454;
         4'd3:    t = 11'd546;
         4'd4:    t = 11'd640;
         4'd5:    t = 11'd753;
         4'd6:    t = 11'd1000;
         4'd7:    t = 11'd1246;
         4'd8:    t = 11'd1359;
         4'd9:    t = 11'd1454;
         4'd10:   t = 11'd1546;
         4'd11:   t = 11'd1641;
         4'd12:   t = 11'd1753;
         4'd13:   t = 11'd2000;
         default: t = 11'd246;
      endcase
      return t;
   endfunction

   function automatic logic [TIME_W-1:0] time_reset(input logic [LANE_W-1:0] i);
      logic [TIME_W-1:0] t;
      case (i)
         3'd0:    t = 11'd0;
         3'd1:    t = 11'd246;
         3'd2:    t = 11'd359;
         3'd3:    t = 11'd454;
         3'd4:    t = 11'd546;
         3'd5:    t = 11'd640;
         3'd6:    t = 11'd753;
         default: t = 11'd1000;
      endcase
      return t;
   endfunction

endpackage
`default_nettype wire

>>> rtl/lcw_lane_cell.sv
// One column lane: time, table position and height, plus its slot in the result chain.
`timescale 1ns / 1ps
`default_nettype none
module lcw_lane_cell #(
   parameter int LANE_ID = 0
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    advance,    // step animation time on this load
   input  wire                    load,       // capture results into the slot
   input  wire                    shift,      // take the neighbor's slot
   input  wire lcw_pkg::slot_type slot_next,  // from the cell above
   output lcw_pkg::slot_type      slot,
   output lcw_pkg::lane_stat_type stat
);
   import lcw_pkg::*;

   logic [TIME_W-1:0] time_ff, time_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [HGT_W-1:0]  height_ff, height_in;
   slot_type          slot_ff, slot_in;

   logic [POS_W-1:0]  pos_safe;
   logic [TIME_W-1:0] ev;
   logic [TIME_W:0]   t_inc;
   logic              hit;

   always_comb begin
      pos_safe  = (pos_ff < POS_W'(TABLE_LEN)) ? pos_ff : '0;
      ev        = event_time(pos_safe);
      t_inc     = {1'b0, time_ff} + 1'b1;
      hit       = advance && (t_inc == {1'b0, ev});
      time_in   = time_ff;
      pos_in    = pos_ff;
      height_in = height_ff;
      if (advance) begin
         time_in = (t_inc >= {1'b0, TIME_WRAP}) ? '0 : t_inc[TIME_W-1:0];
         pos_in  = pos_safe;
         if (hit) begin
            height_in = (ev > RISE_LIMIT) ? height_ff - 1'b1 : height_ff + 1'b1;
            pos_in    = (pos_safe == POS_W'(TABLE_LEN - 1)) ? '0 : pos_safe + 1'b1;
         end
      end
      if (load) begin
         slot_in.height = height_in;
         slot_in.moved  = hit;
      end else if (shift) begin
         slot_in = slot_next;
      end else begin
         slot_in = slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff   <= time_reset(LANE_W'(LANE_ID));
         pos_ff    <= POS_W'(LANE_ID);
         height_ff <= HGT_W'(LANE_ID);
      end else if (load) begin
         time_ff   <= time_in;
         pos_ff    <= pos_in;
         height_ff <= height_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot             = slot_ff;
   assign stat.hit         = hit;
   assign stat.height_next = height_in;

endmodule
`default_nettype wire

>>> rtl/led_cube_column_wave.sv
// Top level of the column-wave animation engine: lane cell chain, round counter, stream ports.
//
// Column-wave engine for an 8x8x8 LED cube, eight column lanes.
// req channel: one transfer per item; req_tdata[0] = tick. A tick of 1 steps animation time
//   for every lane unless mode is none or rounds are done; a tick of 0 only reports the lanes.
// rsp channel: eight transfers per item, lane 0 first, rsp_tlast on lane 7.
// csr channel: index/data writes to mode, plane_index and repeat_count;
//   always ready. Write only while no results are pending.
// Latency: the first result of an item is offered the cycle after its req
//   transfer. The next req is taken in the cycle the last result of the
//   previous item transfers, so the output chain stays full and rsp_tvalid
//   stays high under continuous traffic.
// All eight lane cells update in parallel on the req transfer and load their
//   results into a slot chain that shifts one lane toward the output per rsp
//   transfer.
// Reset: lanes return to their starting times and heights, round count and
//   finished clear, registers read mode diag45, plane 0, repeat 0.
// Stall: while rsp_tready is low the current result holds and req_tready is
//   low once the chain holds a pending item.
`timescale 1ns / 1ps
`default_nettype none
module led_cube_column_wave (
   input  wire         clock,
   input  wire         reset,
   // item input
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,    // [0] tick, [7:1] zero
   // results
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,    // [2:0] lane, [5:3] pos_x, [8:6] pos_y,
                                     // [11:9] pos_z, [12] lit, [13] moved,
                                     // [14] finished, [15] zero
   output logic        rsp_tlast,    // last
   // register writes
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [15:0] csr_data
);
   import lcw_pkg::*;

   // configuration registers
   logic [2:0]         mode_ff;
   logic [COORD_W-1:0] plane_ff;
   logic [REP_W-1:0]   repeat_ff;

   // control
   logic               busy_ff, busy_in;
   logic [LANE_W-1:0]  cnt_ff, cnt_in;
   logic               finished_ff, finished_in;
   logic               armed_ff, armed_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               done_ff, done_in;

   logic               req_xfer, rsp_xfer, none, advance;
   slot_type           slots [LANES+1];
   lane_stat_type      stats [LANES];

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_DIAG45;
         plane_ff  <= '0;
         repeat_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MODE:   mode_ff   <= csr_data[2:0];
            CSR_PLANE:  plane_ff  <= csr_data[COORD_W-1:0];
            CSR_REPEAT: repeat_ff <= csr_data;
            default:    ;
         endcase
      end
   end

   assign none       = mode_ff[2];
   assign rsp_tvalid = busy_ff;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   // next item may enter while the last lane of the current one leaves
   assign req_tready = !busy_ff || (rsp_tready && cnt_ff == LANE_W'(LANES - 1));
   assign req_xfer   = req_tvalid && req_tready;
   assign advance    = req_tdata[0] && !none && !done_ff;

   // lane chain; slot of the cell past the end shifts in empty
   assign slots[LANES] = '0;
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      lcw_lane_cell #(.LANE_ID(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .load      (req_xfer),
         .shift     (rsp_xfer),
         .slot_next (slots[g+1]),
         .slot      (slots[g]),
         .stat      (stats[g])
      );
   end

   // round counting on lane 0 and finish latch
   always_comb begin
      armed_in = armed_ff;
      count_in = count_ff;
      done_in  = done_ff;
      if (advance) begin
         if (stats[0].hit) armed_in = 1'b1;
         if (armed_in && stats[0].height_next == '0) begin
            armed_in = 1'b0;
            if (count_ff != COUNT_MAX) count_in = count_ff + 1'b1;
            if (count_in > {1'b0, repeat_ff}) done_in = 1'b1;
         end
      end
      finished_in = none || done_in;
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (req_xfer) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (rsp_xfer) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LANE_W'(LANES - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         cnt_ff      <= '0;
         armed_ff    <= 1'b0;
         count_ff    <= '0;
         done_ff     <= 1'b0;
         finished_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         if (req_xfer) begin
            armed_ff    <= armed_in;
            count_ff    <= count_in;
            done_ff     <= done_in;
            finished_ff <= finished_in;
         end
      end
   end

   // result fields; keep mode stable while results are pending, the block does not enforce it
   logic [COORD_W-1:0] pos_x, pos_y, pos_z;
   always_comb begin
      pos_x = '0;
      pos_y = '0;
      pos_z = none ? '0 : slots[0].height;
      unique case (mode_ff)
         MODE_DIAG45: begin
            pos_x = cnt_ff;
            pos_y = cnt_ff;
         end
         MODE_DIAG135: begin
            pos_x = cnt_ff;
            pos_y = ~cnt_ff;
         end
         MODE_XPLANE: begin
            pos_x = plane_ff;
            pos_y = cnt_ff;
         end
         MODE_YPLANE: begin
            pos_x = cnt_ff;
            pos_y = plane_ff;
         end
         default: ;
      endcase
   end

   assign rsp_tdata = {1'b0, finished_ff, slots[0].moved, !finished_ff,
                       pos_z, pos_y, pos_x, cnt_ff};
   assign rsp_tlast = (cnt_ff == LANE_W'(LANES - 1));

endmodule
`default_nettype wire

>>> dv/tb_led_cube_column_wave.sv
// Self-checking testbench for the LED cube column-wave engine.
`timescale 1ns / 1ps
module tb_led_cube_column_wave;
   import lcw_pkg::*;

   // ---------------------------------------------------------------------------
   // Types and constants
   // ---------------------------------------------------------------------------

   // One lane report as it travels on the rsp channel
   typedef struct packed {
      logic [LANE_W-1:0]  lane;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [HGT_W-1:0]   pos_z;
      logic               lit;
      logic               moved;
      logic               finished;
      logic               last;
   } lane_report_type;

   // How the eight reports of a directed tick are expected:
   //   CHK_MODEL  - from the lane predictor
   //   CHK_RESET  - lanes still at their power-up spots, diag45, lit
   //   CHK_NONE   - blank mode: everything zero, finished high
   typedef enum logic [1:0] {CHK_MODEL, CHK_RESET, CHK_NONE} check_kind_type;
   typedef enum logic {ROW_TICK, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type   kind;
      logic [1:0]     index;
      logic [15:0]    data;
      logic           tick;
      check_kind_type chk;
   } plan_row_type;

   // Index 3 is not mapped to any register; a write there must change nothing
   localparam logic [1:0] CSR_UNUSED   = 2'd3;
   // Modes 5..7 are alternate spellings of "none"
   localparam logic [2:0] MODE_ALIAS_5 = 3'd5;
   localparam logic [2:0] MODE_ALIAS_6 = 3'd6;
   localparam logic [2:0] MODE_ALIAS_7 = 3'd7;

   localparam int CLK_HALF    = 4;
   localparam int RESET_LEN   = 7;
   localparam int MAX_GAP     = 6;
   localparam int LONG_HOLD   = 90;    // one long rsp back-pressure stretch
   localparam int STALL_LIMIT = 5000;  // cycles with no transfer on any channel
   localparam int TAIL_WAIT   = 24;    // quiet cycles after the last report
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 50;

   // Event-time table each lane walks, and the lanes' starting times
   localparam logic [TIME_W-1:0] EVENT_AT [TABLE_LEN] = '{
      11'd246, 11'd359, 11'd454, 11'd546, 11'd640, 11'd753, 11'd1000,
      11'd1246, 11'd1359, 11'd1454, 11'd1546, 11'd1641, 11'd1753, 11'd2000
   };
   localparam logic [TIME_W-1:0] START_AT [LANES] = '{
      11'd0, 11'd246, 11'd359, 11'd454, 11'd546, 11'd640, 11'd753, 11'd1000
   };

   // Directed opening: reset view, every mode incl. the none aliases, plane
   // and repeat extremes, the unmapped index, both tick values.
   localparam int PLAN_LEN = 26;
   localparam plan_row_type PLAN [PLAN_LEN] = '{
      '{ROW_TICK, CSR_MODE,   16'd0,                  1'b0, CHK_RESET},
      '{ROW_TICK, CSR_MODE,   16'd0,                  1'b1, CHK_MODEL},
      '{ROW_TICK, CSR_MODE,   16'd0,                  1'b0, CHK_MODEL},
      '{ROW_CSR,  CSR_MODE,   16'(MODE_DIAG135),      1'b0, CHK_MODEL},
      '{ROW_TICK, CSR_MODE,   16'd0,                  1'b1, CHK_MODEL},
      '{ROW_CSR,  CSR_PLANE,  16'd7,                  1'b0, CHK_MODEL},
      '{ROW_CSR,  CSR_MODE,   16'(MODE_XPLANE),       1'b0, CHK_MODEL},
      '{ROW_TICK, CSR_MODE,   16'd0,                  1'b1, CHK_MODEL},
      '{ROW_CSR,  CSR_MODE,   16'(MODE_YPLANE),       1'b0, CHK_MODEL},
      '{ROW_TICK, CSR_MODE,   16'd0,                  1'b0, CHK_MODEL},
      '{ROW_CSR,  CSR_PLANE,  16'd0,                  1'b0, CHK_MODEL},
      '{ROW_TICK, CSR_MODE,   16'd0,                  1'b1, CHK_MODEL},
      '{ROW_CSR,  CSR_MODE,   16'(MODE_NONE),         1'b0, CHK_MODEL},
      '{ROW_TICK, CSR_MODE,   16'd0,                  1'b1, CHK_NONE},
      '{ROW_TICK, CSR_MODE,   16'd0,                  1'b0, CHK_NONE},
      '{ROW_CSR,  CSR_MODE,   16'(MODE_ALIAS_7),      1'b0, CHK_MODEL},
      '{ROW_TICK, CSR_MODE,   16'd0,                  1'b1, CHK_NONE},
      '{ROW_CSR,  CSR_MODE,   16'(MODE_ALIAS_5),      1'b0, CHK_MODEL},
      '{ROW_TICK, CSR_MODE,   16'd0,                  1'b1, CHK_NONE},
      '{ROW_CSR,  CSR_MODE,   16'(MODE_ALIAS_6),      1'b0, CHK_MODEL},
      '{ROW_TICK, CSR_MODE,   16'd0,                  1'b0, CHK_NONE},
      '{ROW_CSR,  CSR_REPEAT, 16'hFFFF,               1'b0, CHK_MODEL},
      '{ROW_CSR,  CSR_UNUSED, 16'hFFFF,               1'b0, CHK_MODEL},
      '{ROW_CSR,  CSR_MODE,   16'(MODE_DIAG45),       1'b0, CHK_MODEL},
      '{ROW_TICK, CSR_MODE,   16'd0,                  1'b1, CHK_MODEL},
      '{ROW_TICK, CSR_MODE,   16'd0,                  1'b1, CHK_MODEL}
   };

   // ---------------------------------------------------------------------------
   // DUT signals - every input starts at a known value
   // ---------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;   // [0] tick, [7:1] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [2:0] lane, [5:3] pos_x, [8:6] pos_y,
                                     // [11:9] pos_z, [12] lit, [13] moved,
                                     // [14] finished, [15] zero
   logic        rsp_tlast;           // last
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = 2'd0;
   logic [15:0] csr_data   = 16'd0;

   led_cube_column_wave DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Lane predictor state: its own copy of the lanes and the registers
   // ---------------------------------------------------------------------------
   logic [TIME_W-1:0]  wave_time [LANES];
   logic [POS_W-1:0]   wave_pos  [LANES];
   logic [HGT_W-1:0]   wave_hgt  [LANES];
   logic               round_armed = 1'b0;
   logic [COUNT_W-1:0] rounds      = '0;
   logic               wave_done   = 1'b0;
   logic [2:0]         cfg_mode    = 3'(MODE_DIAG45);
   logic [2:0]         cfg_plane   = 3'd0;
   logic [REP_W-1:0]   cfg_repeat  = '0;

   lane_report_type pending_reports [$];   // reports still owed by the DUT

   int mismatch_count = 0;
   int idle_cycles    = 0;
   bit no_idle        = 1'b0;   // both sides run back to back while set
   bit hold_pending   = 1'b0;   // asks the rsp side for one long stall

   // Apply one tick to the lanes and queue the eight reports it should cause.
   // Directed rows with a fixed expectation still step the lanes so the
   // predictor stays in line with the DUT.
   task automatic advance_wave(input logic tk, input check_kind_type chk);
      logic [TIME_W:0]   t;
      logic [POS_W-1:0]  p;
      logic [TIME_W-1:0] ev;
      logic [LANES-1:0]  hop;
      logic              blank;
      lane_report_type   r;
      int                i;
      blank = cfg_mode[2];   // modes 4..7
      hop   = '0;
      if (tk && !blank && !wave_done) begin
         for (i = 0; i < LANES; i++) begin
            t  = {1'b0, wave_time[i]} + 1'b1;
            // an out-of-range table position reads as entry 0
            p  = (wave_pos[i] < TABLE_LEN) ? wave_pos[i] : '0;
            ev = EVENT_AT[p];
            if (t == {1'b0, ev}) begin
               // first half of the table rises, second half falls; wraps mod 8
               if (ev > RISE_LIMIT) wave_hgt[i] = wave_hgt[i] - 1'b1;
               else                 wave_hgt[i] = wave_hgt[i] + 1'b1;
               if (i == 0) round_armed = 1'b1;
               p      = (p == POS_W'(TABLE_LEN - 1)) ? '0 : p + 1'b1;
               hop[i] = 1'b1;
            end
            wave_pos[i]  = p;
            wave_time[i] = (t >= {1'b0, TIME_WRAP}) ? '0 : t[TIME_W-1:0];
         end
         // lane 0 back on the floor after moving closes one round
         if (round_armed && wave_hgt[0] == '0) begin
            round_armed = 1'b0;
            if (rounds < COUNT_MAX) rounds = rounds + 1'b1;
            if (rounds > {1'b0, cfg_repeat}) wave_done = 1'b1;
         end
      end
      for (i = 0; i < LANES; i++) begin
         r      = '0;
         r.lane = i[LANE_W-1:0];
         r.last = (i == LANES - 1);
         case (chk)
            CHK_RESET: begin
               r.pos_x = i[COORD_W-1:0];
               r.pos_y = i[COORD_W-1:0];
               r.pos_z = i[HGT_W-1:0];
               r.lit   = 1'b1;
            end
            CHK_NONE: begin
               r.finished = 1'b1;
            end
            default: begin
               if (!blank) begin
                  case (mode_type'(cfg_mode))
                     MODE_DIAG45: begin
                        r.pos_x = i[COORD_W-1:0];
                        r.pos_y = i[COORD_W-1:0];
                     end
                     MODE_DIAG135: begin
                        r.pos_x = i[COORD_W-1:0];
                        r.pos_y = COORD_W'(LANES - 1 - i);
                     end
                     MODE_XPLANE: begin
                        r.pos_x = cfg_plane;
                        r.pos_y = i[COORD_W-1:0];
                     end
                     default: begin
                        r.pos_x = i[COORD_W-1:0];
                        r.pos_y = cfg_plane;
                     end
                  endcase
                  r.pos_z = wave_hgt[i];
               end
               r.lit      = !blank && !wave_done;
               r.moved    = hop[i];
               r.finished = blank || wave_done;
            end
         endcase
         pending_reports.push_back(r);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------------

   // Offer one tick after a random gap; the transfer is seen at the edge with
   // the pre-edge handshake values. A gap of 0 keeps req_tvalid high.
   task automatic send_tick(input logic tk, input check_kind_type chk);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, tk};
      do @(posedge clock); while (!req_tready);
      advance_wave(tk, chk);
   endtask

   // Stop offering and wait for every owed report; ends on a later edge so a
   // following drive never lands in the same step as the lowering.
   task automatic drain_reports();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Register write; only called with nothing in flight
   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MODE:   cfg_mode   = value[2:0];
         CSR_PLANE:  cfg_plane  = value[2:0];
         CSR_REPEAT: cfg_repeat = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Receiver side: random stall before each report, one long stall on request
   // ---------------------------------------------------------------------------
   initial begin
      int stall;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
         if (hold_pending) begin
            hold_pending = 1'b0;
            stall        = LONG_HOLD;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && !reset));
      end
   end

   // ---------------------------------------------------------------------------
   // Report checker
   // ---------------------------------------------------------------------------
   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      lane_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            $error("unexpected report transfer: lane %0d", rsp_tdata[2:0]);
            mismatch_count++;
         end else begin
            want = pending_reports.pop_front();
            check_field("lane",     want.lane,     rsp_tdata[2:0]);
            check_field("pos_x",    want.pos_x,    rsp_tdata[5:3]);
            check_field("pos_y",    want.pos_y,    rsp_tdata[8:6]);
            check_field("pos_z",    want.pos_z,    rsp_tdata[11:9]);
            check_field("lit",      want.lit,      rsp_tdata[12]);
            check_field("moved",    want.moved,    rsp_tdata[13]);
            check_field("finished", want.finished, rsp_tdata[14]);
            check_field("last",     want.last,     rsp_tlast);
         end
      end
   end

   // Watchdog: any transfer on any channel counts as progress
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_led_cube_column_wave: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      int n;
      int k;
      int ph;
      logic [2:0]  mode_pick;
      logic [15:0] rep_pick;
      for (n = 0; n < LANES; n++) begin
         wave_time[n] = START_AT[n];
         wave_pos[n]  = n[POS_W-1:0];
         wave_hgt[n]  = n[HGT_W-1:0];
      end
      repeat (RESET_LEN) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening
      for (n = 0; n < PLAN_LEN; n++) begin
         if (PLAN[n].kind == ROW_CSR) begin
            drain_reports();
            write_reg(PLAN[n].index, PLAN[n].data);
         end else begin
            send_tick(PLAN[n].tick, PLAN[n].chk);
         end
      end

      // Random phases: fresh registers each phase, mostly ticking so the
      // lanes actually walk their tables. Upper data bits of the 3-bit
      // registers get junk now and then; it must be ignored.
      for (ph = 0; ph < PHASES; ph++) begin
         drain_reports();
         mode_pick = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                                 : 3'($urandom_range(0, 3));
         write_reg(CSR_MODE, {($urandom_range(0, 1) ? 13'($urandom) : 13'd0), mode_pick});
         write_reg(CSR_PLANE, {($urandom_range(0, 1) ? 13'($urandom) : 13'd0),
                               3'($urandom_range(0, 7))});
         case ($urandom_range(0, 2))
            0:       rep_pick = 16'd0;
            1:       rep_pick = 16'hFFFF;
            default: rep_pick = 16'($urandom);
         endcase
         write_reg(CSR_REPEAT, rep_pick);
         no_idle = (ph == 4);   // one stretch with no idling at all
         for (k = 0; k < PHASE_ITEMS; k++) begin
            // long rsp stall while ticks keep coming: fills the slot chain
            if (ph == 1 && k == 12) hold_pending = 1'b1;
            // sender waits for every owed report mid-phase
            if (ph == 3 && k == 25) drain_reports();
            send_tick(($urandom_range(0, 7) != 0), CHK_MODEL);
         end
      end
      no_idle = 1'b0;

      // Repeat 0 with a real mode, then a short burst of mixed ticks.
      drain_reports();
      write_reg(CSR_REPEAT, 16'd0);
      write_reg(CSR_MODE, 16'($urandom_range(0, 3)));
      for (k = 0; k < 12; k++) send_tick(1'($urandom_range(0, 1)), CHK_MODEL);

      // Mode changes: none blanks everything, a real mode brings the held
      // positions back.
      drain_reports();
      write_reg(CSR_MODE, 16'(MODE_NONE));
      for (k = 0; k < 4; k++) send_tick(1'($urandom_range(0, 1)), CHK_MODEL);
      drain_reports();
      write_reg(CSR_MODE, 16'(MODE_XPLANE));
      write_reg(CSR_PLANE, 16'($urandom_range(0, 7)));
      for (k = 0; k < 8; k++) send_tick(1'($urandom_range(0, 1)), CHK_MODEL);

      // Wait out every owed report plus a quiet tail for stray transfers
      drain_reports();
      repeat (TAIL_WAIT) @(posedge clock);
      if (mismatch_count == 0 && pending_reports.size() == 0)
         $display("tb_led_cube_column_wave: done, clean");
      else
         $display("tb_led_cube_column_wave: done, errors");
      $finish;
   end

endmodule
